### design/pat_pkg.sv
`default_nettype none

package pat_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int TLB_DEPTH   = 64;

   localparam int TBL_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W    = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

   localparam int ADDR_W     = 32;
   localparam int PAGE_W     = 24;
   localparam int FRAME_W    = 24;
   localparam int SHIFT_W    = 5;
   localparam int TLBE_W     = 7;
   localparam int COUNT_W    = 32;
   localparam int OFF_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd8;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
   localparam logic [TLBE_W-1:0]  TLBE_RESET  = 7'd16;
   localparam logic [TLBE_W-1:0]  TLBE_MAX    = TLBE_W'(TLB_DEPTH);

   // slot index is built a few page bits per cycle
   localparam int MOD_STEP  = 4;
   localparam int MOD_CYC   = (PAGE_W + MOD_STEP - 1) / MOD_STEP;
   localparam int MOD_W     = MOD_STEP * MOD_CYC;
   localparam int MOD_CNT_W = $clog2(MOD_CYC + 1);

   localparam logic OP_APPEND    = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TLB_ENTRIES = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [PAGE_W-1:0]  entry_page;
      logic [FRAME_W-1:0] entry_frame;
      logic               entry_valid;
      logic [ADDR_W-1:0]  virtual_address;
   } req_type;

   typedef struct packed {
      logic               page_fault;
      logic [ADDR_W-1:0]  physical_address;
      logic               tlb_hit;
      logic               tlb_enabled;
      logic [COUNT_W-1:0] hit_count;
      logic [COUNT_W-1:0] miss_count;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic               valid;
   } tbl_entry_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } tlb_entry_type;

endpackage

`default_nettype wire

### design/paged_address_translator.sv
`default_nettype none

// Paged address translator with a direct-mapped TLB. An append request writes one page table
// entry; appends beyond the table depth are dropped. On a TLB hit a translate request goes
// through accept, forming the slot index (page mod tlb_entries, 4 page bits per cycle), TLB
// memory read, compare and result. A TLB miss adds the page table walk, one entry per cycle
// through the table memory's read port, stopping at the first matching page. With
// tlb_entries at zero the slot index and TLB read are skipped. Append requests give no
// response. The result sits in an output register, so the next request is taken while it
// waits; a translate only finishes once that register is free. Write page_shift and
// tlb_entries only while idle.
module paged_address_translator (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  pat_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output pat_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_we,
   input  wire  [pat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [pat_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pat_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MOD    = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [SHIFT_W-1:0]   page_shift_ff, page_shift_in;
   logic [TLBE_W-1:0]    tlb_entries_ff, tlb_entries_in;
   logic [TBL_CNT_W-1:0] tbl_count_ff, tbl_count_in;
   logic [TLB_DEPTH-1:0] tlb_valid_ff, tlb_valid_in;
   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [OFF_W-1:0]     offset_ff, offset_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [MOD_W-1:0]     mod_sh_ff, mod_sh_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [SLOT_W-1:0]    rem_ff, rem_in;
   logic [TBL_CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                 chk_live_ff, chk_live_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic                 fault_ff, fault_in;
   logic                 hit_ff, hit_in;

   tbl_entry_type        tbl_mem [TABLE_DEPTH];
   tlb_entry_type        tlb_mem [TLB_DEPTH];
   tbl_entry_type        tbl_rd_ff;
   tlb_entry_type        tlb_rd_ff;
   logic                 tlb_vld_rd_ff;
   logic                 tbl_we;
   logic                 tlb_we;

   logic [SHIFT_W-1:0]   shift_eff;
   logic [TLBE_W-1:0]    slots_eff;
   logic                 enabled;
   logic [ADDR_W-1:0]    page_full;
   logic [PAGE_W-1:0]    page_acc;
   logic [OFF_W-1:0]     offset_acc;
   logic [SLOT_W-1:0]    rem_step;
   logic [ADDR_W-1:0]    paddr;
   logic                 rsp_free;
   logic                 walk_more;

   always_comb begin
      if (page_shift_ff < SHIFT_MIN) begin
         shift_eff = SHIFT_MIN;
      end else if (page_shift_ff > SHIFT_MAX) begin
         shift_eff = SHIFT_MAX;
      end else begin
         shift_eff = page_shift_ff;
      end
      slots_eff  = (tlb_entries_ff > TLBE_MAX) ? TLBE_MAX : tlb_entries_ff;
      enabled    = (slots_eff != '0);
      page_full  = req_data.virtual_address >> shift_eff;
      page_acc   = page_full[PAGE_W-1:0];
      offset_acc = OFF_W'(req_data.virtual_address &
                          ((ADDR_W'(1) << shift_eff) - ADDR_W'(1)));
      paddr      = fault_ff ? '0 : (ADDR_W'(frame_ff) << shift_ff) + ADDR_W'(offset_ff);
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      walk_more  = (rd_idx_ff < tbl_count_ff);
   end

   // restoring remainder, MOD_STEP page bits per cycle
   always_comb begin
      logic [SLOT_W:0]   t;
      logic [SLOT_W-1:0] r;
      r = rem_ff;
      for (int k = 0; k < MOD_STEP; k++) begin
         t = {r, mod_sh_ff[MOD_W-1-k]};
         if (TLBE_W'(t) >= slots_eff) begin
            t = t - (SLOT_W+1)'(slots_eff);
         end
         r = t[SLOT_W-1:0];
      end
      rem_step = r;
   end

   always_comb begin
      state_in       = state_ff;
      page_shift_in  = page_shift_ff;
      tlb_entries_in = tlb_entries_ff;
      tbl_count_in   = tbl_count_ff;
      tlb_valid_in   = tlb_valid_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      shift_in       = shift_ff;
      mod_sh_in      = mod_sh_ff;
      mod_cnt_in     = mod_cnt_ff;
      rem_in         = rem_ff;
      rd_idx_in      = rd_idx_ff;
      chk_live_in    = chk_live_ff;
      frame_in       = frame_ff;
      fault_in       = fault_ff;
      hit_in         = hit_ff;
      tbl_we         = 1'b0;
      tlb_we         = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_PAGE_SHIFT:  page_shift_in  = csr_wdata[SHIFT_W-1:0];
            CSR_TLB_ENTRIES: tlb_entries_in = csr_wdata[TLBE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == OP_APPEND) begin
                  if (tbl_count_ff < TBL_CNT_W'(TABLE_DEPTH)) begin
                     tbl_we       = 1'b1;
                     tbl_count_in = tbl_count_ff + 1'b1;
                  end
               end else begin
                  page_in     = page_acc;
                  offset_in   = offset_acc;
                  shift_in    = shift_eff;
                  mod_sh_in   = MOD_W'(page_acc);
                  mod_cnt_in  = '0;
                  rem_in      = '0;
                  rd_idx_in   = '0;
                  chk_live_in = 1'b0;
                  hit_in      = 1'b0;
                  fault_in    = 1'b0;
                  state_in    = enabled ? ST_MOD : ST_WALK;
               end
            end
         end
         ST_MOD: begin
            rem_in     = rem_step;
            mod_sh_in  = mod_sh_ff << MOD_STEP;
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_CNT_W'(MOD_CYC - 1)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (tlb_vld_rd_ff && tlb_rd_ff.page == page_ff) begin
               hit_in     = 1'b1;
               frame_in   = tlb_rd_ff.frame;
               hit_cnt_in = hit_cnt_ff + 1'b1;
               state_in   = ST_FINISH;
            end else begin
               miss_cnt_in = miss_cnt_ff + 1'b1;
               rd_idx_in   = '0;
               chk_live_in = 1'b0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            chk_live_in = walk_more;
            rd_idx_in   = walk_more ? rd_idx_ff + 1'b1 : rd_idx_ff;
            if (chk_live_ff && tbl_rd_ff.page == page_ff) begin
               state_in = ST_FINISH;
               if (tbl_rd_ff.valid) begin
                  frame_in = tbl_rd_ff.frame;
                  if (enabled) begin
                     tlb_we               = 1'b1;
                     tlb_valid_in[rem_ff] = 1'b1;
                  end
               end else begin
                  fault_in = 1'b1;
               end
            end else if (!chk_live_ff && !walk_more) begin
               fault_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.page_fault       = fault_ff;
               rsp_in.physical_address = paddr;
               rsp_in.tlb_hit          = hit_ff;
               rsp_in.tlb_enabled      = enabled;
               rsp_in.hit_count        = hit_cnt_ff;
               rsp_in.miss_count       = miss_cnt_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         page_shift_ff  <= SHIFT_RESET;
         tlb_entries_ff <= TLBE_RESET;
         tbl_count_ff   <= '0;
         tlb_valid_ff   <= '0;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         page_shift_ff  <= page_shift_in;
         tlb_entries_ff <= tlb_entries_in;
         tbl_count_ff   <= tbl_count_in;
         tlb_valid_ff   <= tlb_valid_in;
         hit_cnt_ff     <= hit_cnt_in;
         miss_cnt_ff    <= miss_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      page_ff     <= page_in;
      offset_ff   <= offset_in;
      shift_ff    <= shift_in;
      mod_sh_ff   <= mod_sh_in;
      mod_cnt_ff  <= mod_cnt_in;
      rem_ff      <= rem_in;
      rd_idx_ff   <= rd_idx_in;
      chk_live_ff <= chk_live_in;
      frame_ff    <= frame_in;
      fault_ff    <= fault_in;
      hit_ff      <= hit_in;
   end

   // page table memory
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_count_ff[TBL_IDX_W-1:0]] <= '{page:  req_data.entry_page,
                                                   frame: req_data.entry_frame,
                                                   valid: req_data.entry_valid};
      end
      tbl_rd_ff <= tbl_mem[rd_idx_ff[TBL_IDX_W-1:0]];
   end

   // tlb memory
   always_ff @(posedge clock) begin
      if (tlb_we) begin
         tlb_mem[rem_ff] <= '{page: page_ff, frame: tbl_rd_ff.frame};
      end
      tlb_rd_ff     <= tlb_mem[rem_ff];
      tlb_vld_rd_ff <= tlb_valid_ff[rem_ff];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hit_cnt_from_check: assert property (@(posedge clock) disable iff (reset)
      (hit_cnt_ff != $past(hit_cnt_ff)) |-> $past(state_ff == ST_CHECK))
      else $error("hit counter moved outside tlb compare");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tlb_hit) |-> (!rsp_ff.page_fault && rsp_ff.tlb_enabled))
      else $error("tlb hit with fault or tlb disabled");

   a_fault_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.page_fault) |-> (rsp_ff.physical_address == '0))
      else $error("faulting request with nonzero address");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (rd_idx_ff <= tbl_count_ff))
      else $error("table walk past loaded entries");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      tbl_count_ff <= TBL_CNT_W'(TABLE_DEPTH))
      else $error("page table count past depth");

endmodule

`default_nettype wire

### sim/paged_address_translator_test.sv
`default_nettype none

module paged_address_translator_test;

   timeunit 1ns;
   timeprecision 1ps;

   import pat_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int SEGMENTS      = 9;
   localparam int SEGMENT_ITEMS = 115;

   typedef enum {STEP_REQUEST, STEP_WRITE} step_kind_type;

   typedef struct {
      step_kind_type              kind;
      req_type                    request;
      bit                         known;
      rsp_type                    outcome;
      logic [CSR_IDX_W-1:0]       reg_index;
      logic [CSR_DATA_W-1:0]      reg_value;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor state
   logic [SHIFT_W-1:0]     page_shift_setting = SHIFT_RESET;
   logic [TLBE_W-1:0]      tlb_size_setting = TLBE_RESET;
   tbl_entry_type          page_table [TABLE_DEPTH];
   int                     table_used = 0;
   tlb_entry_type          tlb_slot [TLB_DEPTH];
   bit                     tlb_slot_valid [TLB_DEPTH];
   logic [COUNT_W-1:0]     hits_so_far = '0;
   logic [COUNT_W-1:0]     misses_so_far = '0;

   rsp_type                pending_translations [$];
   step_row_type           directed_steps [$];
   int                     mismatches = 0;
   int                     gap_percent = 0;
   int                     stall_percent = 0;

   paged_address_translator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_percent);
   end

   function automatic int unsigned active_shift();
      if (page_shift_setting < SHIFT_MIN) return SHIFT_MIN;
      if (page_shift_setting > SHIFT_MAX) return SHIFT_MAX;
      return page_shift_setting;
   endfunction

   task automatic model_request(input req_type r, output bit answered, output rsp_type result);
      int unsigned shift;
      int unsigned slots;
      int unsigned slot;
      logic [31:0] page;
      logic [31:0] offset;
      logic [FRAME_W-1:0] frame;
      logic [63:0] wide;
      bit enabled;
      bit hit;
      bit found;
      bit fault;
      answered = 1'b0;
      result = '0;
      if (r.operation == OP_APPEND) begin
         if (table_used < TABLE_DEPTH) begin
            page_table[table_used] = '{r.entry_page, r.entry_frame, r.entry_valid};
            table_used++;
         end
      end else begin
         shift = active_shift();
         page = r.virtual_address >> shift;
         offset = r.virtual_address & ((32'd1 << shift) - 32'd1);
         slots = (tlb_size_setting > TLB_DEPTH) ? TLB_DEPTH : tlb_size_setting;
         enabled = (slots != 0);
         hit = 1'b0;
         found = 1'b0;
         fault = 1'b0;
         frame = '0;
         slot = 0;
         if (enabled) begin
            slot = page % slots;
            if (tlb_slot_valid[slot] && {8'h00, tlb_slot[slot].page} == page) begin
               hit = 1'b1;
               frame = tlb_slot[slot].frame;
               hits_so_far++;
            end else begin
               misses_so_far++;
            end
         end
         if (!hit) begin
            for (int i = 0; i < table_used; i++) begin
               if (!found && {8'h00, page_table[i].page} == page) begin
                  found = 1'b1;
                  if (page_table[i].valid) begin
                     frame = page_table[i].frame;
                     if (enabled) begin
                        tlb_slot[slot] = '{page[PAGE_W-1:0], frame};
                        tlb_slot_valid[slot] = 1'b1;
                     end
                  end else begin
                     fault = 1'b1;
                  end
               end
            end
            if (!found) fault = 1'b1;
         end
         wide = ({40'h0, frame} << shift) + {32'h0, offset};
         result.page_fault = fault;
         result.physical_address = fault ? 32'h0 : wide[31:0];
         result.tlb_hit = hit;
         result.tlb_enabled = enabled;
         result.hit_count = hits_so_far;
         result.miss_count = misses_so_far;
         answered = 1'b1;
      end
   endtask

   function automatic step_row_type append_row(input logic [23:0] page, input logic [23:0] frame,
                                               input logic valid);
      step_row_type row;
      row = '{default: '0, kind: STEP_REQUEST};
      row.request = '{OP_APPEND, page, frame, valid, $urandom};
      return row;
   endfunction

   function automatic step_row_type translate_row(input logic [31:0] address);
      step_row_type row;
      row = '{default: '0, kind: STEP_REQUEST};
      row.request = '{OP_TRANSLATE, 24'($urandom), 24'($urandom), 1'($urandom), address};
      return row;
   endfunction

   function automatic step_row_type checked_row(input logic [31:0] address, input logic fault,
                                                input logic [31:0] paddr, input logic hit,
                                                input logic enabled, input logic [31:0] hits,
                                                input logic [31:0] misses);
      step_row_type row;
      row = translate_row(address);
      row.known = 1'b1;
      row.outcome = '{fault, paddr, hit, enabled, hits, misses};
      return row;
   endfunction

   function automatic step_row_type write_row(input logic [CSR_IDX_W-1:0] index,
                                              input logic [CSR_DATA_W-1:0] value);
      step_row_type row;
      row = '{default: '0, kind: STEP_WRITE};
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int unsigned pick;
      int unsigned shift;
      logic [31:0] page;
      pick = $urandom_range(99);
      if (pick < 60) r.entry_page = 24'($urandom_range(127));
      else if (pick < 80) r.entry_page = 24'($urandom_range(16'hFFFF));
      else r.entry_page = 24'($urandom);
      r.entry_frame = 24'($urandom);
      r.entry_valid = ($urandom_range(99) < 80);
      r.virtual_address = $urandom;
      r.operation = ($urandom_range(99) < ((table_used < TABLE_DEPTH) ? 35 : 5)) ?
                    OP_APPEND : OP_TRANSLATE;
      if (r.operation == OP_TRANSLATE) begin
         shift = active_shift();
         pick = $urandom_range(99);
         if (pick < 85) begin
            if (pick < 70 && table_used != 0)
               page = {8'h00, page_table[$urandom_range(table_used - 1)].page};
            else
               page = $urandom_range(127);
            r.virtual_address = (page << shift) | ($urandom & ((32'd1 << shift) - 32'd1));
         end
      end
      return r;
   endfunction

   task automatic send_request(input req_type r, input bit known, input rsp_type literal);
      bit answered;
      rsp_type predicted;
      if ($urandom_range(99) < gap_percent) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_percent);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      model_request(r, answered, predicted);
      if (answered) pending_translations.push_back(known ? literal : predicted);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_PAGE_SHIFT) page_shift_setting = value[SHIFT_W-1:0];
      else tlb_size_setting = value[TLBE_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_translations.size() == 0) begin
            $display("%0t: response with none pending, expected nothing got %h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = pending_translations.pop_front();
            check_field("page_fault", 32'(want.page_fault), 32'(rsp_data.page_fault));
            check_field("physical_address", want.physical_address, rsp_data.physical_address);
            check_field("tlb_hit", 32'(want.tlb_hit), 32'(rsp_data.tlb_hit));
            check_field("tlb_enabled", 32'(want.tlb_enabled), 32'(rsp_data.tlb_enabled));
            check_field("hit_count", want.hit_count, rsp_data.hit_count);
            check_field("miss_count", want.miss_count, rsp_data.miss_count);
         end
      end
   end

   initial begin
      int counted;
      int phase;
      logic [CSR_DATA_W-1:0] shift_value;
      logic [CSR_DATA_W-1:0] size_value;
      req_type r;

      // after reset: page shift 12, 16 slots, empty table
      directed_steps.push_back(checked_row(32'h0000_0000, 1'b1, 32'h0, 1'b0, 1'b1, 0, 1));
      directed_steps.push_back(checked_row(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b1, 0, 2));
      directed_steps.push_back(append_row(24'h000000, 24'hFFFFFF, 1'b1));
      directed_steps.push_back(append_row(24'h0FFFFF, 24'h000001, 1'b1));
      directed_steps.push_back(append_row(24'h000005, 24'h000ABC, 1'b0));
      directed_steps.push_back(append_row(24'hFFFFFF, 24'h123456, 1'b1));
      // physical address wraps at 32 bits
      directed_steps.push_back(checked_row(32'h0000_0FFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 0, 3));
      directed_steps.push_back(checked_row(32'h0000_0123, 1'b0, 32'hFFFF_F123, 1'b1, 1'b1, 1, 3));
      directed_steps.push_back(checked_row(32'hFFFF_FFFF, 1'b0, 32'h0000_1FFF, 1'b0, 1'b1, 1, 4));
      // entry marked invalid
      directed_steps.push_back(checked_row(32'h0000_5000, 1'b1, 32'h0, 1'b0, 1'b1, 1, 5));
      directed_steps.push_back(checked_row(32'hFFFF_F000, 1'b0, 32'h0000_1000, 1'b1, 1'b1, 2, 5));
      // shift below range, tlb bypassed
      directed_steps.push_back(write_row(CSR_PAGE_SHIFT, 7'd0));
      directed_steps.push_back(write_row(CSR_TLB_ENTRIES, 7'd0));
      directed_steps.push_back(checked_row(32'h0000_00FF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 2, 5));
      directed_steps.push_back(checked_row(32'hFFFF_FFFF, 1'b0, 32'h1234_56FF, 1'b0, 1'b0, 2, 5));
      // shift above range, tlb size above depth, no flush on resize
      directed_steps.push_back(write_row(CSR_PAGE_SHIFT, 7'd31));
      directed_steps.push_back(write_row(CSR_TLB_ENTRIES, 7'd127));
      directed_steps.push_back(checked_row(32'h0005_1234, 1'b1, 32'h0, 1'b0, 1'b1, 2, 6));
      directed_steps.push_back(translate_row(32'h0000_ABCD));
      directed_steps.push_back(translate_row(32'hFFFF_0000));
      directed_steps.push_back(write_row(CSR_PAGE_SHIFT, 7'd16));
      directed_steps.push_back(write_row(CSR_TLB_ENTRIES, 7'd1));
      directed_steps.push_back(translate_row(32'h0000_FFFF));
      directed_steps.push_back(translate_row(32'h0001_0000));
      directed_steps.push_back(append_row(24'h000001, 24'h000000, 1'b1));
      directed_steps.push_back(translate_row(32'h0001_FFFF));
      directed_steps.push_back(translate_row(32'h0000_8000));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_percent = 25;
      stall_percent = 47;
      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == STEP_WRITE) begin
            settle_block();
            write_register(directed_steps[k].reg_index, directed_steps[k].reg_value);
         end else begin
            send_request(directed_steps[k].request, directed_steps[k].known,
                         directed_steps[k].outcome);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         phase = seg / 3;
         gap_percent = (phase == 0) ? 25 : (phase == 1) ? 47 : 0;
         stall_percent = (phase == 0) ? 47 : (phase == 1) ? 25 : 0;
         case (seg)
            0: begin shift_value = 7'd12; size_value = 7'd16; end
            1: begin shift_value = 7'd8;  size_value = 7'd1;  end
            2: begin shift_value = 7'd16; size_value = 7'd64; end
            3: begin shift_value = 7'd0;  size_value = 7'd127; end
            4: begin shift_value = 7'd31; size_value = 7'd0;  end
            5: begin shift_value = 7'd10; size_value = 7'd3;  end
            default: begin
               shift_value = 7'($urandom_range(31));
               size_value = 7'($urandom_range(80));
            end
         endcase
         settle_block();
         write_register(CSR_PAGE_SHIFT, shift_value);
         write_register(CSR_TLB_ENTRIES, size_value);
         counted = 0;
         while (counted < SEGMENT_ITEMS) begin
            r = random_request();
            if (r.operation == OP_TRANSLATE || table_used < TABLE_DEPTH) counted++;
            send_request(r, 1'b0, '0);
         end
      end

      settle_block();
      if (pending_translations.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_translations.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("[paged_address_translator] OK");
      end else begin
         $display("[paged_address_translator] ERROR");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("%0t: timeout with %0d responses pending", $time, pending_translations.size());
      $display("[paged_address_translator] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
